[hdl/hap_pkg.sv]
// ----------------------------------------------------------------------------
// hap_pkg: shared types and constants of the artifact heat analyzer
// Geometry limits, derived widths, register map, pixel event and config types.
// ----------------------------------------------------------------------------
`default_nettype none

package hap_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 1024;

  localparam int COL_W   = $clog2(MAX_WIDTH);
  localparam int ROW_W   = $clog2(MAX_HEIGHT);
  localparam int DIM_W   = $clog2(MAX_WIDTH + 1);
  localparam int HDIM_W  = $clog2(MAX_HEIGHT + 1);
  localparam int RING_DEPTH = 2 * MAX_WIDTH;
  localparam int SLOT_W  = $clog2(RING_DEPTH);
  localparam int SPAN_W  = SLOT_W + 1;

  localparam int PIX_W   = 8;
  localparam int GEOM_W  = 11;
  localparam int SENS_W  = 8;

  localparam int ADDR_W  = 4;
  localparam int DATA_W  = 32;

  localparam int QDEPTH  = 4;
  localparam int QPTR_W  = $clog2(QDEPTH);

  localparam logic [15:0] GRAY_KR = 16'd77;
  localparam logic [15:0] GRAY_KG = 16'd150;
  localparam logic [15:0] GRAY_KB = 16'd29;

  // floor(p/18) == (p*58255)>>20 for every 16-bit product
  localparam logic [15:0] DIV18_MUL = 16'd58255;
  localparam int          DIV18_SH  = 20;
  // floor(e/3) == (e*171)>>9 for 8-bit e
  localparam logic [7:0]  DIV3_MUL  = 8'd171;
  localparam int          DIV3_SH   = 9;

  localparam logic [7:0] PAL_SEG1 = 8'd85;
  localparam logic [7:0] PAL_SEG2 = 8'd170;
  localparam logic [7:0] PAL_BASE = 8'd128;
  localparam logic [7:0] PIX_MAX  = 8'd255;

  typedef enum logic [1:0] {
    REG_WIDTH  = 2'd0,
    REG_HEIGHT = 2'd1,
    REG_SENS   = 2'd2,
    REG_NONE   = 2'd3
  } hap_reg_t;

  typedef struct packed {
    logic [GEOM_W-1:0] frame_width;
    logic [GEOM_W-1:0] frame_height;
    logic [SENS_W-1:0] sensitivity;
  } hap_cfg_t;

  typedef struct packed {
    logic [PIX_W-1:0]  gray;
    logic [SLOT_W-1:0] wslot;
    logic [SLOT_W-1:0] rslot;
    logic              emit;
    logic [COL_W-1:0]  x;
    logic [ROW_W-1:0]  y;
    logic [DIM_W-1:0]  w;
    logic [HDIM_W-1:0] h;
    logic              last;
  } hap_ev_t;

endpackage

`default_nettype wire

[hdl/hap_if.sv]
// ----------------------------------------------------------------------------
// hap_if: stream channels of the artifact heat analyzer
// Valid/ready channels for input pixels and for result items.
// ----------------------------------------------------------------------------
`default_nettype none

interface hap_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] pixel_red;
  logic [7:0] pixel_green;
  logic [7:0] pixel_blue;
  logic       is_flush;

  modport source (output valid, pixel_red, pixel_green, pixel_blue, is_flush,
                  input ready);
  modport sink   (input valid, pixel_red, pixel_green, pixel_blue, is_flush,
                  output ready);
endinterface

interface hap_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] edge_level;
  logic [7:0] block_level;
  logic [7:0] heat_level;
  logic [7:0] heat_red;
  logic [7:0] heat_green;
  logic [7:0] heat_blue;
  logic       frame_last;

  modport source (output valid, edge_level, block_level, heat_level, heat_red,
                  heat_green, heat_blue, frame_last, input ready);
  modport sink   (input valid, edge_level, block_level, heat_level, heat_red,
                  heat_green, heat_blue, frame_last, output ready);
endinterface

`default_nettype wire

[hdl/hap_cfg.sv]
// ----------------------------------------------------------------------------
// hap_cfg: configuration registers
// APB-style register file for frame geometry and boundary sensitivity.
// ----------------------------------------------------------------------------
`default_nettype none

module hap_cfg
  import hap_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [DATA_W-1:0] pwdata,
  output logic      [DATA_W-1:0] prdata,
  output logic                   pready,
  output hap_cfg_t               cfg
);

  hap_cfg_t cfg_r;
  hap_reg_t idx;
  logic     wr_en;

  assign idx    = hap_reg_t'(paddr[3:2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg    = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.frame_width  <= GEOM_W'(640);
      cfg_r.frame_height <= GEOM_W'(480);
      cfg_r.sensitivity  <= SENS_W'(55);
    end else if (wr_en) begin
      unique case (idx)
        REG_WIDTH:  cfg_r.frame_width  <= pwdata[GEOM_W-1:0];
        REG_HEIGHT: cfg_r.frame_height <= pwdata[GEOM_W-1:0];
        REG_SENS:   cfg_r.sensitivity  <= pwdata[SENS_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_WIDTH:  prdata = DATA_W'(cfg_r.frame_width);
      REG_HEIGHT: prdata = DATA_W'(cfg_r.frame_height);
      REG_SENS:   prdata = DATA_W'(cfg_r.sensitivity);
      default:    prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

[hdl/hap_queue.sv]
// ----------------------------------------------------------------------------
// hap_queue: event queue
// Short FIFO of pixel events between the front and the back.
// ----------------------------------------------------------------------------
`default_nettype none

module hap_queue
  import hap_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    push,
  input  hap_ev_t      push_ev,
  output logic         space,
  input  wire logic    pop,
  output hap_ev_t      head,
  output logic         nonempty
);

  hap_ev_t           mem_r [QDEPTH];
  logic [QPTR_W-1:0] wptr_r, rptr_r;
  logic [QPTR_W:0]   cnt_r;

  assign space    = (cnt_r != (QPTR_W+1)'(QDEPTH));
  assign nonempty = (cnt_r != '0);
  assign head     = mem_r[rptr_r];

  always_ff @(posedge clk) begin
    if (push) mem_r[wptr_r] <= push_ev;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      if (push) wptr_r <= wptr_r + QPTR_W'(1);
      if (pop)  rptr_r <= rptr_r + QPTR_W'(1);
      priority if (push && !pop) cnt_r <= cnt_r + (QPTR_W+1)'(1);
      else if (pop && !push)     cnt_r <= cnt_r - (QPTR_W+1)'(1);
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> space) else $error("queue push while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> nonempty) else $error("queue pop while empty");
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= (QPTR_W+1)'(QDEPTH)) else $error("queue count out of range");
`endif

endmodule

`default_nettype wire

[hdl/hap_front.sv]
// ----------------------------------------------------------------------------
// hap_front: item intake
// Converts pixels to gray, tracks input/result raster positions and drain
// state, and turns each useful item into an event for the back.
// ----------------------------------------------------------------------------
`default_nettype none

module hap_front
  import hap_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  hap_cfg_t   cfg,
  hap_in_if.sink     in_ch,
  output logic       push,
  output hap_ev_t    push_ev,
  input  wire logic  space
);

  logic [COL_W-1:0]  in_col_r, in_col_nxt;
  logic [ROW_W-1:0]  in_row_r, in_row_nxt;
  logic [COL_W-1:0]  out_col_r, out_col_nxt;
  logic [ROW_W-1:0]  out_row_r, out_row_nxt;
  logic [DIM_W-1:0]  lat_w_r, lat_w_nxt;
  logic [HDIM_W-1:0] lat_h_r, lat_h_nxt;
  logic [SLOT_W-1:0] ptr_r, ptr_nxt;
  logic              draining_r, draining_nxt;

  logic [DIM_W-1:0]  w_cfg, w_use;
  logic [HDIM_W-1:0] h_cfg, h_use;
  logic              acc, is_pix, is_drain, frame_start, emit_pix, last;
  logic [SLOT_W-1:0] p_use;
  logic [SPAN_W-1:0] p_ext, w_ext, r_off;
  logic [15:0]       gray_sum;

  always_comb begin
    if (cfg.frame_width == '0)                 w_cfg = DIM_W'(1);
    else if (int'(cfg.frame_width) > MAX_WIDTH) w_cfg = DIM_W'(MAX_WIDTH);
    else                                       w_cfg = DIM_W'(cfg.frame_width);
    if (cfg.frame_height == '0)                  h_cfg = HDIM_W'(1);
    else if (int'(cfg.frame_height) > MAX_HEIGHT) h_cfg = HDIM_W'(MAX_HEIGHT);
    else                                         h_cfg = HDIM_W'(cfg.frame_height);
  end

  assign in_ch.ready = space;
  assign acc         = in_ch.valid && space;
  assign is_drain    = acc && draining_r;
  assign is_pix      = acc && !draining_r && !in_ch.is_flush;
  assign frame_start = (in_col_r == '0) && (in_row_r == '0);
  assign w_use       = (is_pix && frame_start) ? w_cfg : lat_w_r;
  assign h_use       = (is_pix && frame_start) ? h_cfg : lat_h_r;
  assign p_use       = (is_pix && frame_start) ? '0 : ptr_r;
  // result q = n - w - 1 becomes due once n reaches w + 1
  assign emit_pix    = (in_row_r >= ROW_W'(2)) ||
                       ((in_row_r == ROW_W'(1)) && (in_col_r != '0));
  assign last        = (DIM_W'(out_col_r) + DIM_W'(1) == w_use) &&
                       (HDIM_W'(out_row_r) + HDIM_W'(1) == h_use);
  assign p_ext       = SPAN_W'(p_use);
  assign w_ext       = SPAN_W'(w_use);
  // a single-line frame drains from item n = w on, so its window sits one sample later
  assign r_off       = (h_use == HDIM_W'(1)) ? w_ext - SPAN_W'(1) : w_ext;
  assign gray_sum    = 16'(in_ch.pixel_red) * GRAY_KR + 16'(in_ch.pixel_green) * GRAY_KG
                     + 16'(in_ch.pixel_blue) * GRAY_KB;

  always_comb begin
    push           = is_pix || is_drain;
    push_ev.gray   = gray_sum[15:8];
    push_ev.wslot  = p_use;
    push_ev.rslot  = (p_ext >= r_off) ? SLOT_W'(p_ext - r_off)
                                      : SLOT_W'(p_ext + (w_ext << 1) - r_off);
    push_ev.emit   = is_drain || emit_pix;
    push_ev.x      = out_col_r;
    push_ev.y      = out_row_r;
    push_ev.w      = w_use;
    push_ev.h      = h_use;
    push_ev.last   = last;
  end

  always_comb begin
    in_col_nxt   = in_col_r;
    in_row_nxt   = in_row_r;
    out_col_nxt  = out_col_r;
    out_row_nxt  = out_row_r;
    lat_w_nxt    = lat_w_r;
    lat_h_nxt    = lat_h_r;
    ptr_nxt      = ptr_r;
    draining_nxt = draining_r;
    if (push) begin
      ptr_nxt = (p_ext + SPAN_W'(1) == (w_ext << 1)) ? '0 : p_use + SLOT_W'(1);
      if (push_ev.emit) begin
        if (DIM_W'(out_col_r) + DIM_W'(1) >= w_use) begin
          out_col_nxt = '0;
          out_row_nxt = out_row_r + ROW_W'(1);
        end else begin
          out_col_nxt = out_col_r + COL_W'(1);
        end
      end
    end
    if (is_pix) begin
      lat_w_nxt = w_use;
      lat_h_nxt = h_use;
      if (DIM_W'(in_col_r) + DIM_W'(1) >= w_use) begin
        in_col_nxt = '0;
        if (HDIM_W'(in_row_r) + HDIM_W'(1) >= h_use) begin
          in_row_nxt   = '0;
          draining_nxt = 1'b1;
        end else begin
          in_row_nxt = in_row_r + ROW_W'(1);
        end
      end else begin
        in_col_nxt = in_col_r + COL_W'(1);
      end
    end
    if (is_drain && last) begin
      draining_nxt = 1'b0;
      in_col_nxt   = '0;
      in_row_nxt   = '0;
      out_col_nxt  = '0;
      out_row_nxt  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_col_r   <= '0;
      in_row_r   <= '0;
      out_col_r  <= '0;
      out_row_r  <= '0;
      lat_w_r    <= DIM_W'(640);
      lat_h_r    <= HDIM_W'(480);
      ptr_r      <= '0;
      draining_r <= 1'b0;
    end else begin
      in_col_r   <= in_col_nxt;
      in_row_r   <= in_row_nxt;
      out_col_r  <= out_col_nxt;
      out_row_r  <= out_row_nxt;
      lat_w_r    <= lat_w_nxt;
      lat_h_r    <= lat_h_nxt;
      ptr_r      <= ptr_nxt;
      draining_r <= draining_nxt;
    end
  end

`ifndef SYNTHESIS
  a_drain_col: assert property (@(posedge clk) disable iff (!rst_n)
    draining_r |-> (in_col_r == '0) && (in_row_r == '0))
    else $error("input position moved while draining");
  a_drain_end: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(draining_r) |-> $past(is_drain && last))
    else $error("drain ended before the final result");
  a_pix_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    is_pix && emit_pix |-> !last)
    else $error("final result issued before the frame was complete");
`endif

endmodule

`default_nettype wire

[hdl/hap_back.sv]
// ----------------------------------------------------------------------------
// hap_back: analysis pipeline
// Two-line gray ring, 5-point window, edge/boundary measures, scaling,
// heat level and palette. The whole pipeline stalls on result backpressure.
// ----------------------------------------------------------------------------
`default_nettype none

module hap_back
  import hap_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  hap_cfg_t   cfg,
  input  hap_ev_t    ev,
  input  wire logic  ev_valid,
  output logic       pop,
  hap_out_if.source  out_ch
);

  logic adv;

  // stage A: ring access
  logic [PIX_W-1:0] ring_a [RING_DEPTH];
  logic [PIX_W-1:0] ring_b [RING_DEPTH];
  logic             va_r;
  hap_ev_t          ea_r;
  logic [PIX_W-1:0] rd_old_r, rd_w_r;

  // stage B: window
  logic             vb_r;
  hap_ev_t          eb_r;
  logic [PIX_W-1:0] rgt_r, cen_r, lft_r, prv_r, blw_r, oldp_r, abv_r;

  // stages C..F and output
  logic             vc_r, vd_r, ve_r, vf_r, vo_r;
  logic             lc_r, ld_r, le_r, lf_r, lo_r;
  logic [7:0]       edge_c_r, dmax_c_r, edge_d_r, edge_e_r, edge_f_r, edge_o_r;
  logic [15:0]      prod_d_r;
  logic [7:0]       blk_e_r, e3_e_r, blk_f_r, heat_f_r, blk_o_r, heat_o_r;
  logic [7:0]       red_o_r, grn_o_r, blu_o_r;

  assign adv = !vo_r || out_ch.ready;
  assign pop = adv && ev_valid;

  always_ff @(posedge clk) begin
    if (pop) begin
      rd_old_r         <= ring_a[ev.wslot];
      ring_a[ev.wslot] <= ev.gray;
      rd_w_r           <= ring_b[ev.rslot];
      ring_b[ev.wslot] <= ev.gray;
      ea_r             <= ev;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && va_r) begin
      rgt_r  <= rd_w_r;
      cen_r  <= rgt_r;
      lft_r  <= cen_r;
      prv_r  <= ea_r.gray;
      blw_r  <= prv_r;
      oldp_r <= rd_old_r;
      abv_r  <= oldp_r;
      eb_r   <= ea_r;
    end
  end

  function automatic logic [7:0] absd(input logic [7:0] a, input logic [7:0] b);
    return (a > b) ? a - b : b - a;
  endfunction

  logic       interior, j0, j1, j2, j3;
  logic [8:0] esum;
  logic [7:0] dmax;
  always_comb begin
    interior = (eb_r.x != '0) && (eb_r.y != '0) &&
               (int'(eb_r.x) + 1 < int'(eb_r.w)) && (int'(eb_r.y) + 1 < int'(eb_r.h));
    esum = 9'(absd(rgt_r, lft_r)) + 9'(absd(blw_r, abv_r));
    j0 = (int'(eb_r.x) >= 8) && (eb_r.x[2:0] == 3'd0);
    j1 = (eb_r.x[2:0] == 3'd7) && (int'(eb_r.x) + 1 < int'(eb_r.w));
    j2 = (int'(eb_r.y) >= 8) && (eb_r.y[2:0] == 3'd0);
    j3 = (eb_r.y[2:0] == 3'd7) && (int'(eb_r.y) + 1 < int'(eb_r.h));
    dmax = '0;
    if (j0 && absd(cen_r, lft_r) > dmax) dmax = absd(cen_r, lft_r);
    if (j1 && absd(rgt_r, cen_r) > dmax) dmax = absd(rgt_r, cen_r);
    if (j2 && absd(cen_r, abv_r) > dmax) dmax = absd(cen_r, abv_r);
    if (j3 && absd(blw_r, cen_r) > dmax) dmax = absd(blw_r, cen_r);
  end

  logic [31:0] q18;
  logic [16:0] e3p;
  logic [8:0]  hsum;
  assign q18  = 32'(prod_d_r) * 32'(DIV18_MUL);
  assign e3p  = 17'(edge_d_r) * 17'(DIV3_MUL);
  assign hsum = 9'(blk_e_r) + 9'(e3_e_r);

  logic [7:0] pt, pt3, pr, pg, pb;
  logic [9:0] pt3w;
  always_comb begin
    if (heat_f_r < PAL_SEG1)      pt = heat_f_r;
    else if (heat_f_r < PAL_SEG2) pt = heat_f_r - PAL_SEG1;
    else                          pt = heat_f_r - PAL_SEG2;
    pt3w = {1'b0, pt, 1'b0} + 10'(pt);
    pt3  = pt3w[7:0];
    priority if (heat_f_r < PAL_SEG1) begin
      pr = '0;
      pg = pt3;
      pb = PAL_BASE + {1'b0, pt[7:1]};
    end else if (heat_f_r < PAL_SEG2) begin
      pr = pt3;
      pg = PIX_MAX;
      pb = PIX_MAX - pt3;
    end else begin
      pr = PIX_MAX;
      pg = PIX_MAX - pt3;
      pb = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      edge_c_r <= (interior && esum[8]) ? PIX_MAX : (interior ? esum[7:0] : '0);
      dmax_c_r <= dmax;
      lc_r     <= eb_r.last;

      prod_d_r <= 16'(dmax_c_r) * 16'(cfg.sensitivity);
      edge_d_r <= edge_c_r;
      ld_r     <= lc_r;

      blk_e_r  <= (q18[31:DIV18_SH] > 12'(PIX_MAX)) ? PIX_MAX : q18[DIV18_SH+7:DIV18_SH];
      e3_e_r   <= e3p[DIV3_SH+7:DIV3_SH];
      edge_e_r <= edge_d_r;
      le_r     <= ld_r;

      heat_f_r <= hsum[8] ? PIX_MAX : hsum[7:0];
      blk_f_r  <= blk_e_r;
      edge_f_r <= edge_e_r;
      lf_r     <= le_r;

      heat_o_r <= heat_f_r;
      blk_o_r  <= blk_f_r;
      edge_o_r <= edge_f_r;
      red_o_r  <= pr;
      grn_o_r  <= pg;
      blu_o_r  <= pb;
      lo_r     <= lf_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
      vc_r <= 1'b0;
      vd_r <= 1'b0;
      ve_r <= 1'b0;
      vf_r <= 1'b0;
      vo_r <= 1'b0;
    end else if (adv) begin
      va_r <= ev_valid;
      vb_r <= va_r && ea_r.emit;
      vc_r <= vb_r;
      vd_r <= vc_r;
      ve_r <= vd_r;
      vf_r <= ve_r;
      vo_r <= vf_r;
    end
  end

  assign out_ch.valid       = vo_r;
  assign out_ch.edge_level  = edge_o_r;
  assign out_ch.block_level = blk_o_r;
  assign out_ch.heat_level  = heat_o_r;
  assign out_ch.heat_red    = red_o_r;
  assign out_ch.heat_green  = grn_o_r;
  assign out_ch.heat_blue   = blu_o_r;
  assign out_ch.frame_last  = lo_r;

`ifndef SYNTHESIS
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> $stable(vf_r) && $stable(heat_f_r))
    else $error("pipeline moved during a stall");
  a_no_pop_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |-> !pop) else $error("event taken during a stall");
  a_heat_floor: assert property (@(posedge clk) disable iff (!rst_n)
    vo_r |-> heat_o_r >= blk_o_r) else $error("heat below block level");
`endif

endmodule

`default_nettype wire

[hdl/block_artifact_heat_analyzer.sv]
// Path: a pixel's result is due one line plus one pixel of input later; from that
//   item's acceptance it reaches the output register through the queue, ring read,
//   window, measure, gain multiply, divide-by-18 multiply, heat and palette stages.
// Throughput: one item per cycle; every stage moves each cycle unless the output stalls.
// Reset: synchronous, active low; clears positions, drain state, queue and valids;
//   registers return to 640 x 480, sensitivity 55. Line ring needs no clearing.
// ----------------------------------------------------------------------------
// block_artifact_heat_analyzer: top level
// Front intake, event queue, analysis back end and configuration registers.
// ----------------------------------------------------------------------------
`default_nettype none

module block_artifact_heat_analyzer
  import hap_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  hap_in_if.sink                 in_ch,
  hap_out_if.source              out_ch,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [DATA_W-1:0] pwdata,
  output logic      [DATA_W-1:0] prdata,
  output logic                   pready
);

  hap_cfg_t cfg;
  hap_ev_t  push_ev, head;
  logic     push, space, pop, nonempty;

  hap_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  hap_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg),
    .in_ch   (in_ch),
    .push    (push),
    .push_ev (push_ev),
    .space   (space)
  );

  hap_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_ev  (push_ev),
    .space    (space),
    .pop      (pop),
    .head     (head),
    .nonempty (nonempty)
  );

  hap_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg),
    .ev       (head),
    .ev_valid (nonempty),
    .pop      (pop),
    .out_ch   (out_ch)
  );

endmodule

`default_nettype wire

[tb/sv/block_artifact_heat_analyzer_test.sv]
// ----------------------------------------------------------------------------
// block_artifact_heat_analyzer_test: stream-level regression of the analyzer
// Drives frames of RGB pixels with drain items, random gaps and output
// stalls. It also reprograms geometry and gain over APB. Every result is
// compared with an in-bench model of the two-line gray ring.
// ----------------------------------------------------------------------------
module block_artifact_heat_analyzer_test;
  import hap_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    bit [7:0] red;
    bit [7:0] green;
    bit [7:0] blue;
    bit       flush;
  } pix_item_t;

  typedef struct {
    bit [7:0] edge_lvl;
    bit [7:0] block_lvl;
    bit [7:0] heat;
    bit [7:0] hr;
    bit [7:0] hg;
    bit [7:0] hb;
    bit       last;
  } heat_res_t;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int SETTLE_CYCLES  = 20;

  logic              clk;
  logic              rst_n;
  logic              psel, penable, pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  hap_in_if  in_ch ();
  hap_out_if out_ch ();

  block_artifact_heat_analyzer i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch.sink),
    .out_ch (out_ch.source),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready)
  );

  always begin
    clk = 1'b1;
    #4;
    clk = 1'b0;
    #4;
  end

  // ---------------- analyzer model ----------------
  bit [7:0]    ring [RING_DEPTH];
  bit [7:0]    displaced;
  int unsigned in_col, in_row, out_col, out_row, lat_w, lat_h;
  bit          draining;
  int unsigned reg_w, reg_h, reg_sens;
  heat_res_t   heat_due [$];
  int          errors;

  function automatic int unsigned clamp_dim(int unsigned v, int unsigned maxv);
    if (v == 0) return 1;
    return (v > maxv) ? maxv : v;
  endfunction

  function automatic int unsigned absd(int unsigned a, int unsigned b);
    return (a > b) ? a - b : b - a;
  endfunction

  function automatic int unsigned gray_at(int unsigned k);
    int unsigned n, span;
    n = in_row * lat_w + in_col;
    span = 2 * lat_w;
    // the slot just overwritten still holds this sample in the displaced copy
    if (n >= span + 1 && k == n - span - 1) return displaced;
    return ring[(k % span) % RING_DEPTH];
  endfunction

  function automatic int unsigned gain_jump(int unsigned d);
    int unsigned v;
    v = d * reg_sens / 18;
    return (v > 255) ? 255 : v;
  endfunction

  function automatic void emit_result();
    int unsigned x, y, w, h, q, c, e, blk, t, ht;
    heat_res_t r;
    x = out_col; y = out_row; w = lat_w; h = lat_h;
    q = y * w + x;
    c = gray_at(q);
    e = 0;
    blk = 0;
    if (x > 0 && y > 0 && x + 1 < w && y + 1 < h) begin
      e = absd(gray_at(q + 1), gray_at(q - 1)) + absd(gray_at(q + w), gray_at(q - w));
      if (e > 255) e = 255;
    end
    if (x >= 8 && (x & 7) == 0) begin
      t = gain_jump(absd(c, gray_at(q - 1))); if (t > blk) blk = t;
    end
    if (((x + 1) & 7) == 0 && x + 1 < w) begin
      t = gain_jump(absd(gray_at(q + 1), c)); if (t > blk) blk = t;
    end
    if (y >= 8 && (y & 7) == 0) begin
      t = gain_jump(absd(c, gray_at(q - w))); if (t > blk) blk = t;
    end
    if (((y + 1) & 7) == 0 && y + 1 < h) begin
      t = gain_jump(absd(gray_at(q + w), c)); if (t > blk) blk = t;
    end
    ht = blk + e / 3;
    if (ht > 255) ht = 255;
    r.edge_lvl = 8'(e); r.block_lvl = 8'(blk); r.heat = 8'(ht);
    if (ht < 85) begin
      r.hr = 8'd0; r.hg = 8'(ht * 3); r.hb = 8'(128 + ht / 2);
    end else if (ht < 170) begin
      t = ht - 85; r.hr = 8'(t * 3); r.hg = 8'd255; r.hb = 8'(255 - t * 3);
    end else begin
      t = ht - 170; r.hr = 8'd255; r.hg = (t * 3 > 255) ? 8'd0 : 8'(255 - t * 3);
      r.hb = 8'd0;
    end
    r.last = (x + 1 == w) && (y + 1 == h);
    heat_due.push_back(r);
    if (x + 1 >= w) begin
      out_col = 0; out_row = y + 1;
    end else begin
      out_col = x + 1;
    end
  endfunction

  function automatic void model_step(pix_item_t it);
    int unsigned n, g, slot;
    bit fin;
    if (draining) begin
      fin = (out_col + 1 >= lat_w) && (out_row + 1 >= lat_h);
      emit_result();
      if (fin) begin
        draining = 0;
        in_col = 0; in_row = 0; out_col = 0; out_row = 0;
      end
      return;
    end
    if (it.flush) return;
    if (in_col == 0 && in_row == 0) begin
      lat_w = clamp_dim(reg_w, MAX_WIDTH);
      lat_h = clamp_dim(reg_h, MAX_HEIGHT);
    end
    n = in_row * lat_w + in_col;
    if (n >= lat_w + 1) emit_result();
    g = (it.red * 77 + it.green * 150 + it.blue * 29) >> 8;
    slot = (n % (2 * lat_w)) % RING_DEPTH;
    displaced = ring[slot];
    ring[slot] = 8'(g);
    if (in_col + 1 >= lat_w) begin
      in_col = 0;
      in_row++;
      if (in_row >= lat_h) draining = 1;
    end else begin
      in_col++;
    end
  endfunction

  // ---------------- pixel driver ----------------
  pix_item_t pix_q [$];
  pix_item_t on_bus;
  int        gap_left, burst_left;
  int        sent_items;

  always @(posedge clk) begin : pixel_driver
    pix_item_t nxt;
    logic      fire;
    logic      give;
    fire = in_ch.valid && in_ch.ready;
    give = 1'b0;
    if (rst_n) begin
      if (fire) model_step(on_bus);
      if (!in_ch.valid || fire) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (pix_q.size() > 0) begin
          nxt = pix_q.pop_front();
          on_bus = nxt;
          give = 1'b1;
          if (burst_left > 0) burst_left--;
          if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            case ($urandom_range(0, 5))
              0, 1, 2: gap_left = 0;
              3, 4:    gap_left = $urandom_range(1, 6);
              default: gap_left = $urandom_range(7, 20);
            endcase
          end
        end
        in_ch.valid       <= give;
        in_ch.pixel_red   <= nxt.red;
        in_ch.pixel_green <= nxt.green;
        in_ch.pixel_blue  <= nxt.blue;
        in_ch.is_flush    <= nxt.flush;
      end
    end
  end

  // ---------------- result receiver ----------------
  logic [15:0] stall_mask;
  int          pat_pos, hold_cnt;
  bit          hold_req, hold_done;

  always @(posedge clk) begin : result_receiver
    if (rst_n) begin
      if (hold_req && !hold_done && hold_cnt == 0) begin
        hold_cnt = 400;
        hold_done = 1;
      end
      if (pat_pos == 0) begin
        case ($urandom_range(0, 3))
          0:       stall_mask = 16'hFFFF;
          1:       stall_mask = 16'($urandom_range(0, 16'hFFFF)) | 16'h8421;
          default: stall_mask = 16'($urandom_range(0, 16'hFFFF));
        endcase
      end
      pat_pos = (pat_pos + 1) % 16;
      if (hold_cnt > 0) begin
        hold_cnt--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= stall_mask[pat_pos];
      end
    end
  end

  function automatic void check_field(string fname, int unsigned exp_v, int unsigned act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, fname, exp_v, act_v);
      errors++;
    end
  endfunction

  always @(posedge clk) begin : result_monitor
    heat_res_t r;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (heat_due.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual heat %0d", $time,
                 out_ch.heat_level);
        errors++;
      end else begin
        r = heat_due.pop_front();
        check_field("edge_level", r.edge_lvl, out_ch.edge_level);
        check_field("block_level", r.block_lvl, out_ch.block_level);
        check_field("heat_level", r.heat, out_ch.heat_level);
        check_field("heat_red", r.hr, out_ch.heat_red);
        check_field("heat_green", r.hg, out_ch.heat_green);
        check_field("heat_blue", r.hb, out_ch.heat_blue);
        check_field("frame_last", r.last, out_ch.frame_last);
      end
    end
  end

  int quiet_cycles;

  always @(posedge clk) begin : watchdog
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || psel)
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // ---------------- stimulus ----------------
  int unsigned gen_w, gen_h, gen_col, gen_row;
  bit [7:0]    tile_base [64];
  int          frame_style;

  task automatic wait_idle();
    while (pix_q.size() > 0 || in_ch.valid || heat_due.size() > 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic reg_write(hap_reg_t idx, int unsigned val);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_W'(idx) << 2;
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    case (idx)
      REG_WIDTH:  reg_w = val & 32'h7FF;
      REG_HEIGHT: reg_h = val & 32'h7FF;
      REG_SENS:   reg_sens = val & 32'hFF;
      default:    ;
    endcase
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic set_geometry(int unsigned w, int unsigned h, int unsigned sens);
    reg_write(REG_WIDTH, w);
    reg_write(REG_HEIGHT, h);
    reg_write(REG_SENS, sens);
  endtask

  function automatic void put(bit [7:0] r, bit [7:0] g, bit [7:0] b, bit fl);
    pix_item_t it;
    it.red = r; it.green = g; it.blue = b; it.flush = fl;
    pix_q.push_back(it);
    sent_items++;
  endfunction

  function automatic void put_random(bit fl);
    put(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
        8'($urandom_range(0, 255)), fl);
  endfunction

  // latches the frame geometry the way the block does at the first pixel
  function automatic void start_frame();
    gen_w = clamp_dim(reg_w, MAX_WIDTH);
    gen_h = clamp_dim(reg_h, MAX_HEIGHT);
    gen_col = 0;
    gen_row = 0;
    frame_style = $urandom_range(0, 2);
    foreach (tile_base[i]) tile_base[i] = 8'($urandom_range(0, 255));
  endfunction

  function automatic void push_pixels(int unsigned count);
    bit [7:0] base;
    bit [7:0] nz;
    repeat (count) begin
      if ($urandom_range(0, 19) == 0)
        put_random(1'b1);
      if (frame_style == 0) begin
        put_random(1'b0);
      end else begin
        // flat 8x8 tiles, noise-free or with light noise, make grid jumps dominate
        base = tile_base[((gen_row / 8) * 7 + gen_col / 8) % 64];
        nz = (frame_style == 1) ? 8'd0 : 8'($urandom_range(0, 6));
        put(base ^ nz, base ^ nz, (frame_style == 1) ? ~base : base, 0);
      end
      if (gen_col + 1 >= gen_w) begin
        gen_col = 0;
        gen_row++;
      end else begin
        gen_col++;
      end
    end
  endfunction

  function automatic void push_drain();
    int unsigned total;
    total = gen_w * gen_h;
    repeat ((total < gen_w + 1) ? total : gen_w + 1) begin
      if ($urandom_range(0, 1))
        put_random(1'b0);
      else
        put_random(1'b1);
    end
  endfunction

  task automatic run_frame(int unsigned w, int unsigned h, int unsigned sens);
    wait_idle();
    set_geometry(w, h, sens);
    start_frame();
    push_pixels(gen_w * gen_h);
    push_drain();
  endtask

  initial begin
    in_ch.valid = 1'b0;
    in_ch.pixel_red = '0;
    in_ch.pixel_green = '0;
    in_ch.pixel_blue = '0;
    in_ch.is_flush = 1'b0;
    out_ch.ready = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    rst_n = 1'b0;
    errors = 0;
    sent_items = 0;
    gap_left = 0;
    burst_left = 1;
    pat_pos = 0;
    stall_mask = 16'hFFFF;
    hold_cnt = 0;
    hold_req = 0;
    hold_done = 0;
    quiet_cycles = 0;
    draining = 0;
    in_col = 0; in_row = 0; out_col = 0; out_row = 0;
    reg_w = 640; reg_h = 480; reg_sens = 55;
    lat_w = 640; lat_h = 480;
    displaced = 0;
    foreach (ring[i]) ring[i] = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // zero geometry counts as a single pixel; a flush outside draining is dropped
    wait_idle();
    set_geometry(0, 0, 255);
    reg_write(REG_NONE, 32'hFFFF_FFFF);
    start_frame();
    put(8'hFF, 8'hFF, 8'hFF, 1);
    put(8'hFF, 8'hFF, 8'hFF, 0);
    put(8'h00, 8'h00, 8'h00, 1);

    // 3x3 of extremes, drained partly by pixels
    wait_idle();
    set_geometry(3, 3, 0);
    start_frame();
    put(8'h00, 8'h00, 8'h00, 0); put(8'hFF, 8'hFF, 8'hFF, 0); put(8'hFF, 8'h00, 8'h00, 0);
    put(8'h00, 8'hFF, 8'h00, 0); put(8'h00, 8'h00, 8'hFF, 0); put(8'hFF, 8'hFF, 8'hFF, 0);
    put(8'h00, 8'h00, 8'h00, 0); put(8'hFF, 8'hFF, 8'hFF, 0); put(8'h80, 8'h7F, 8'h01, 0);
    put(8'hFF, 8'hFF, 8'hFF, 0); put(8'h00, 8'h00, 8'h00, 1);
    put(8'h12, 8'h34, 8'h56, 0); put(8'h00, 8'h00, 8'h00, 1);

    run_frame(8, 8, 18);
    run_frame(16, 12, 255);

    // single long line with a long output hold-off
    wait_idle();
    set_geometry(200, 1, 37);
    start_frame();
    hold_req = 1;
    push_pixels(gen_w * gen_h);
    push_drain();

    run_frame(1, 60, 200);

    // new geometry mid-frame only applies to the next frame
    wait_idle();
    set_geometry(24, 16, $urandom_range(0, 255));
    start_frame();
    push_pixels(200);
    wait_idle();
    set_geometry(10, 6, $urandom_range(0, 255));
    push_pixels(gen_w * gen_h - 200);
    push_drain();
    run_frame(10, 6, 90);

    while (sent_items < 1950) begin
      run_frame($urandom_range(1, 24), $urandom_range(1, 16), $urandom_range(0, 255));
    end

    wait_idle();
    if (errors == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule

[sim.f]
hdl/hap_pkg.sv
hdl/hap_if.sv
hdl/hap_cfg.sv
hdl/hap_queue.sv
hdl/hap_front.sv
hdl/hap_back.sv
hdl/block_artifact_heat_analyzer.sv
tb/sv/block_artifact_heat_analyzer_test.sv
